### sv/http_header_field_tokenizer_core_assert.svh
// assertion macros for the header field tokenizer
`ifndef HTTP_HEADER_FIELD_TOKENIZER_CORE_ASSERT_SVH
`define HTTP_HEADER_FIELD_TOKENIZER_CORE_ASSERT_SVH

// checked only while out of reset
`define HHFT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define HHFT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/hhft_pkg.sv
// ----------------------------------------------------------------------------
// hhft_pkg
// shared codes, characters and types of the header field tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hhft_pkg;

  localparam int unsigned OFF_W = 10;

  localparam logic [OFF_W-1:0] MAX_OFF_RESET = OFF_W'(512);

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] ROLE_SEP   = 2'd0;
  localparam logic [1:0] ROLE_KEY   = 2'd1;
  localparam logic [1:0] ROLE_VALUE = 2'd2;
  localparam logic [1:0] ROLE_AFTER = 2'd3;

  localparam logic [1:0] STAT_BUSY  = 2'd0;
  localparam logic [1:0] STAT_DONE  = 2'd1;
  localparam logic [1:0] STAT_ERROR = 2'd2;

  typedef struct packed {
    logic [1:0] byte_role;
    logic       pair_done;
    logic [1:0] parse_status;
  } hhft_result_t;

endpackage

`default_nettype wire

### sv/http_header_field_tokenizer_core.sv
// ----------------------------------------------------------------------------
// http_header_field_tokenizer_core
// tags each header byte as key, value, separator or after-header byte
// ----------------------------------------------------------------------------
//  channel   dir   tdata          tuser                         tlast
//  s_axis    in    data_byte      start_of_request              -
//  m_axis    out   out_byte       byte_role, parse_status       pair_done
//  cfg       in    max_value_offset (write enable + data)       -
//
//  one item per cycle sustained while m_axis is ready; m_axis_tvalid rises once
//  an accepted item has passed the input register, parser logic and result register
//  the parse state register updates once per item as it enters the result stage
//  synchronous reset: parser at line start, offset zero, limit 512, stages empty
//  a stall on m_axis holds the result; s_axis keeps accepting into the input
//  register until that register is also full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module http_header_field_tokenizer_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  output      logic                       s_axis_tready,
  input  wire logic [7:0]                 s_axis_tdata,  // [7:0] data_byte
  input  wire logic [0:0]                 s_axis_tuser,  // [0] start_of_request
  output      logic                       m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output      logic [7:0]                 m_axis_tdata,  // [7:0] out_byte
  output      logic [3:0]                 m_axis_tuser,  // [1:0] byte_role, [3:2] parse_status
  output      logic                       m_axis_tlast,  // pair_done
  input  wire logic                       cfg_we,
  input  wire logic [hhft_pkg::OFF_W-1:0] cfg_wdata
);
  import hhft_pkg::*;

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             in_sor;
  logic             out_valid;
  logic [7:0]       out_byte;
  hhft_result_t     out_res;
  logic [OFF_W-1:0] max_value_offset;

  logic             advance;
  logic             step_en;
  hhft_result_t     step_res;

  assign advance       = !out_valid || m_axis_tready;
  assign step_en       = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  hhft_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .step_en          (step_en),
    .data_byte        (in_byte),
    .start_of_request (in_sor),
    .max_value_offset (max_value_offset),
    .result           (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value_offset <= MAX_OFF_RESET;
    end else if (cfg_we) begin
      max_value_offset <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_sor  <= s_axis_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_byte <= in_byte;
      out_res  <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tuser  = {out_res.parse_status, out_res.byte_role};
  assign m_axis_tlast  = out_res.pair_done;

endmodule

`default_nettype wire

### sv/hhft_parser.sv
// ----------------------------------------------------------------------------
// hhft_parser
// parse state machine: tags one byte per step and advances on step_en
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hhft_parser (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step_en,
  input  wire logic [7:0]                data_byte,
  input  wire logic                      start_of_request,
  input  wire logic [hhft_pkg::OFF_W-1:0] max_value_offset,
  output hhft_pkg::hhft_result_t         result
);
  import hhft_pkg::*;

  typedef enum logic [3:0] {
    ST_START  = 4'd0,
    ST_KEY    = 4'd1,
    ST_COLON  = 4'd2,
    ST_SPACE  = 4'd3,
    ST_VALUE  = 4'd4,
    ST_CR     = 4'd5,
    ST_LF     = 4'd6,
    ST_END_CR = 4'd7,
    ST_DONE   = 4'd8,
    ST_ERROR  = 4'd9
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [OFF_W-1:0] value_offset;
  logic [OFF_W-1:0] value_offset_next;

  state_t           cur;
  logic [OFF_W-1:0] cur_off;
  logic [OFF_W:0]   off_inc;
  logic [1:0]       role;
  logic             done;
  logic             is_crlf;

  always_comb begin
    // start_of_request restarts before the byte is handled
    cur               = start_of_request ? ST_START : state;
    cur_off           = start_of_request ? '0 : value_offset;
    off_inc           = {1'b0, cur_off} + (OFF_W+1)'(1);
    is_crlf           = (data_byte == CH_CR) || (data_byte == CH_LF);
    state_next        = cur;
    value_offset_next = cur_off;
    role              = ROLE_SEP;
    done              = 1'b0;
    unique case (cur)
      ST_START: begin
        if (!is_crlf) begin
          state_next = ST_KEY;
          role       = ROLE_KEY;
        end
      end
      ST_KEY: begin
        if (data_byte == CH_COLON) begin
          state_next = ST_COLON;
        end else if (is_crlf) begin
          state_next = ST_ERROR;
        end else begin
          role = ROLE_KEY;
        end
      end
      ST_COLON: begin
        state_next = (data_byte == CH_SPACE) ? ST_SPACE : ST_ERROR;
      end
      ST_SPACE: begin
        // first value byte, whatever it is
        value_offset_next = '0;
        state_next        = ST_VALUE;
        role              = ROLE_VALUE;
      end
      ST_VALUE: begin
        if (data_byte == CH_CR) begin
          state_next = ST_CR;
        end else if (off_inc > {1'b0, max_value_offset}) begin
          state_next = ST_ERROR;
        end else begin
          value_offset_next = off_inc[OFF_W-1:0];
          role              = ROLE_VALUE;
        end
      end
      ST_CR: begin
        if (data_byte == CH_LF) begin
          state_next = ST_LF;
          done       = 1'b1;
        end else begin
          state_next = ST_ERROR;
        end
      end
      ST_LF: begin
        if (data_byte == CH_CR) begin
          state_next = ST_END_CR;
        end else begin
          state_next = ST_KEY;
          role       = ROLE_KEY;
        end
      end
      ST_END_CR: begin
        state_next = (data_byte == CH_LF) ? ST_DONE : ST_ERROR;
      end
      ST_DONE: begin
        role = ROLE_AFTER;
      end
      default: begin
        state_next = ST_ERROR;
      end
    endcase

    if (state_next == ST_ERROR) begin
      role = ROLE_AFTER;
    end

    result.byte_role    = role;
    result.pair_done    = done;
    result.parse_status = (state_next == ST_DONE)  ? STAT_DONE  :
                          (state_next == ST_ERROR) ? STAT_ERROR : STAT_BUSY;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_START;
      value_offset <= '0;
    end else if (step_en) begin
      state        <= state_next;
      value_offset <= value_offset_next;
    end
  end

endmodule

`default_nettype wire

### sv/hhft_checker.sv
// ----------------------------------------------------------------------------
// hhft_checker
// port-level checks on the header field tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "http_header_field_tokenizer_core_assert.svh"

module hhft_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [3:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);
  import hhft_pkg::*;

  `HHFT_ASSERT_ALWAYS(a_empty_after_reset, clk, rst |=> !m_axis_tvalid, "item after reset")

  `HHFT_ASSERT(a_after_role_status, clk, rst, m_axis_tvalid && (m_axis_tuser[1:0] == ROLE_AFTER) |-> (m_axis_tuser[3:2] != STAT_BUSY), "after-header role while busy")

  `HHFT_ASSERT(a_pair_done_lf, clk, rst, m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata == CH_LF) && (m_axis_tuser[1:0] == ROLE_SEP) && (m_axis_tuser[3:2] == STAT_BUSY), "pair done on a byte other than lf")

  `HHFT_ASSERT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled item changed")

endmodule

bind http_header_field_tokenizer_core hhft_checker u_hhft_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
